// ===== src/three_sphere_radical_center_defines.svh =====
// ---------------------------------------------------------------------------
// three_sphere_radical_center_defines
// assertion macros shared by the radical center checker
// ---------------------------------------------------------------------------
`ifndef THREE_SPHERE_RADICAL_CENTER_DEFINES_SVH
`define THREE_SPHERE_RADICAL_CENTER_DEFINES_SVH

// implication checked at every clock edge outside reset
`define TSRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never be seen outside reset
`define TSRC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== src/tsrc_pkg.sv =====
// ---------------------------------------------------------------------------
// tsrc_pkg
// types, widths and pipeline latencies of the radical center block
// ---------------------------------------------------------------------------
package tsrc_pkg;

  // field widths
  localparam int C_W   = 32;
  localparam int R_W   = 31;
  localparam int THR_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1;

  localparam logic signed [C_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [C_W-1:0] C_MIN = 32'sh8000_0000;

  // multiplier digit size
  localparam int MUL_DIG = 8;

  // datapath widths: differences, second order terms, fourth order terms, numerators, divisor
  localparam int W1 = C_W + 1;
  localparam int W3 = 70;
  localparam int W4 = 2 * W3 + 1;
  localparam int W5 = W4 + W1;
  localparam int W6 = W5 + 1;
  localparam int WN = W6 + 1;
  localparam int WD = W4 + 1;

  // quotient bits kept before saturation
  localparam int QW = 34;

  // latencies
  localparam int LAT1    = (W1 + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int LAT3    = (W3 + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int LAT5    = (W1 + MUL_DIG - 1) / MUL_DIG + 2;
  localparam int DIV_LAT = QW + 1;
  localparam int NV      = 6 + LAT1 + LAT3 + LAT5 + DIV_LAT;

  typedef struct packed {
    logic signed [C_W-1:0] center0_x;
    logic signed [C_W-1:0] center0_y;
    logic signed [C_W-1:0] center0_z;
    logic signed [C_W-1:0] center1_x;
    logic signed [C_W-1:0] center1_y;
    logic signed [C_W-1:0] center1_z;
    logic signed [C_W-1:0] center2_x;
    logic signed [C_W-1:0] center2_y;
    logic signed [C_W-1:0] center2_z;
    logic [R_W-1:0]        radius0;
    logic [R_W-1:0]        radius1;
    logic [R_W-1:0]        radius2;
  } in_t;

  typedef struct packed {
    logic signed [C_W-1:0] res_x;
    logic signed [C_W-1:0] res_y;
    logic signed [C_W-1:0] res_z;
    logic                  found;
  } out_t;

endpackage

// ===== src/tsrc_delay.sv =====
// ---------------------------------------------------------------------------
// tsrc_delay
// fixed length shift line that keeps side data aligned with the pipeline
// ---------------------------------------------------------------------------
module tsrc_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [D];

  // shift by one each cycle
  always_ff @(posedge clk) begin
    sh_r[0] <= d;
    for (int i = 1; i < D; i++) begin
      sh_r[i] <= sh_r[i-1];
    end
  end

  assign q = sh_r[D-1];

endmodule

// ===== src/tsrc_mul.sv =====
// ---------------------------------------------------------------------------
// tsrc_mul
// pipelined signed multiplier, one digit of the second operand per stage
// ---------------------------------------------------------------------------
module tsrc_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int DG  = tsrc_pkg::MUL_DIG;
  localparam int ND  = (WB + DG - 1) / DG;
  localparam int WBP = ND * DG;
  localparam int WAC = WA + WBP;
  localparam int WP  = WA + WB;

  logic [WA-1:0]  amag;
  logic [WB-1:0]  bmag;
  logic [WA-1:0]  ma_r  [ND+1];
  logic [WBP-1:0] mb_r  [ND+1];
  logic           sg_r  [ND+1];
  logic [WAC-1:0] acc_r [ND+1];
  logic [WP-1:0]  p_r;

  // magnitudes and sign
  assign amag = a[WA-1] ? -a : a;
  assign bmag = b[WB-1] ? -b : b;

  always_ff @(posedge clk) begin
    ma_r[0]  <= amag;
    mb_r[0]  <= WBP'(bmag);
    sg_r[0]  <= a[WA-1] ^ b[WB-1];
    acc_r[0] <= '0;
  end

  // one partial product per stage
  for (genvar k = 1; k <= ND; k++) begin : g_dig
    logic [WA+DG-1:0] pp;
    assign pp = ma_r[k-1] * mb_r[k-1][DG*k-1 -: DG];
    always_ff @(posedge clk) begin
      acc_r[k] <= acc_r[k-1] + (WAC'(pp) << (DG * (k - 1)));
      ma_r[k]  <= ma_r[k-1];
      mb_r[k]  <= mb_r[k-1];
      sg_r[k]  <= sg_r[k-1];
    end
  end

  // apply sign
  always_ff @(posedge clk) begin
    p_r <= WP'(sg_r[ND] ? -acc_r[ND] : acc_r[ND]);
  end

  assign p = p_r;

endmodule

// ===== src/tsrc_div.sv =====
// ---------------------------------------------------------------------------
// tsrc_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ---------------------------------------------------------------------------
module tsrc_div #(
  parameter int WNUM = 176,
  parameter int WDEN = 142,
  parameter int QB   = 34
) (
  input  logic            clk,
  input  logic [WNUM-1:0] num,
  input  logic [WDEN-1:0] den,
  input  logic            neg,
  output logic [QB-1:0]   q,
  output logic            ovf,
  output logic            neg_o
);

  localparam int WR = ((WDEN + QB > WNUM) ? WDEN + QB : WNUM) + 1;

  logic [WR-1:0]   rem_r [QB+1];
  logic [WDEN-1:0] den_r [QB+1];
  logic [QB-1:0]   q_r   [QB+1];
  logic            ovf_r [QB+1];
  logic            neg_r [QB+1];

  // quotient that does not fit is flagged up front
  always_ff @(posedge clk) begin
    rem_r[0] <= WR'(num);
    den_r[0] <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= WR'(num) >= (WR'(den) << QB);
    neg_r[0] <= neg;
  end

  // compare and subtract, most significant quotient bit first
  for (genvar j = 1; j <= QB; j++) begin : g_bit
    localparam int B = QB - j;
    logic [WR-1:0] dsh;
    logic          ge;
    assign dsh = WR'(den_r[j-1]) << B;
    assign ge  = rem_r[j-1] >= dsh;
    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? rem_r[j-1] - dsh : rem_r[j-1];
      q_r[j]   <= q_r[j-1] | (ge ? (QB'(1) << B) : QB'(0));
      den_r[j] <= den_r[j-1];
      ovf_r[j] <= ovf_r[j-1];
      neg_r[j] <= neg_r[j-1];
    end
  end

  assign q     = q_r[QB];
  assign ovf   = ovf_r[QB];
  assign neg_o = neg_r[QB];

endmodule

// ===== src/three_sphere_radical_center.sv =====
// ---------------------------------------------------------------------------
// three_sphere_radical_center
// radical center of three spheres in signed Q16.16, fully pipelined
// ---------------------------------------------------------------------------
// One beat is accepted in every cycle (busy stays low) and its result beat
// appears on out_data with out_strobe high, in order, for exactly one cycle;
// the receiver cannot stall, so results must be taken as they come. The
// latency is set by three banks of digit-serial multipliers (8 bits of one
// operand per stage) and a 34-stage restoring divider per coordinate. found
// is low and the coordinates are zero when the first two centers are closer
// than the threshold or the third lies closer than the threshold to their
// line. degenerate_threshold is written through cfg_we/cfg_wdata; the user
// must write it only while no beat is in flight, the block does not enforce it.
module three_sphere_radical_center (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  tsrc_pkg::in_t                    in_data,
  output logic                             out_strobe,
  output tsrc_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [tsrc_pkg::THR_W-1:0]       cfg_wdata
);

  localparam int C_W = tsrc_pkg::C_W;
  localparam int W1  = tsrc_pkg::W1;
  localparam int W3  = tsrc_pkg::W3;
  localparam int W4  = tsrc_pkg::W4;
  localparam int W5  = tsrc_pkg::W5;
  localparam int W6  = tsrc_pkg::W6;
  localparam int WN  = tsrc_pkg::WN;
  localparam int WD  = tsrc_pkg::WD;
  localparam int QW  = tsrc_pkg::QW;
  localparam int SW  = QW + 2;
  localparam int NV  = tsrc_pkg::NV;
  localparam int D_UV = tsrc_pkg::LAT1 + tsrc_pkg::LAT3 + 2;
  localparam int D_P0 = tsrc_pkg::LAT1 + tsrc_pkg::LAT3 + tsrc_pkg::LAT5 + 3
                        + tsrc_pkg::DIV_LAT;
  localparam int D_OK = tsrc_pkg::LAT5 + 1 + tsrc_pkg::DIV_LAT;

  // configuration and valid tracking
  logic [tsrc_pkg::THR_W-1:0]   thr_r;
  logic [2*tsrc_pkg::THR_W-1:0] t2_r;
  logic [NV-1:0]                vpipe_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= tsrc_pkg::THR_RESET;
      vpipe_r <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      vpipe_r <= {vpipe_r[NV-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    t2_r <= thr_r * thr_r;
  end

  // input register
  tsrc_pkg::in_t in_r;

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_data;
    end
  end

  // differences from the first center
  logic signed [C_W-1:0] c0 [3];
  logic signed [C_W-1:0] c1 [3];
  logic signed [C_W-1:0] c2 [3];
  logic signed [W1-1:0]  u_r [3];
  logic signed [W1-1:0]  v_r [3];
  logic signed [C_W-1:0] p0_r [3];
  logic signed [W1-1:0]  r_r [3];

  assign c0[0] = in_r.center0_x;
  assign c0[1] = in_r.center0_y;
  assign c0[2] = in_r.center0_z;
  assign c1[0] = in_r.center1_x;
  assign c1[1] = in_r.center1_y;
  assign c1[2] = in_r.center1_z;
  assign c2[0] = in_r.center2_x;
  assign c2[1] = in_r.center2_y;
  assign c2[2] = in_r.center2_z;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u_r[i]  <= W1'(c1[i]) - W1'(c0[i]);
      v_r[i]  <= W1'(c2[i]) - W1'(c0[i]);
      p0_r[i] <= c0[i];
    end
    r_r[0] <= W1'({1'b0, in_r.radius0});
    r_r[1] <= W1'({1'b0, in_r.radius1});
    r_r[2] <= W1'({1'b0, in_r.radius2});
  end

  // dot products and squared radii
  logic signed [2*W1-1:0] puu [3];
  logic signed [2*W1-1:0] pvv [3];
  logic signed [2*W1-1:0] puv [3];
  logic signed [2*W1-1:0] prr [3];

  for (genvar i = 0; i < 3; i++) begin : g_m1
    tsrc_mul #(.WA(W1), .WB(W1)) u_muu (.clk(clk), .a(u_r[i]), .b(u_r[i]), .p(puu[i]));
    tsrc_mul #(.WA(W1), .WB(W1)) u_mvv (.clk(clk), .a(v_r[i]), .b(v_r[i]), .p(pvv[i]));
    tsrc_mul #(.WA(W1), .WB(W1)) u_muv (.clk(clk), .a(u_r[i]), .b(v_r[i]), .p(puv[i]));
    tsrc_mul #(.WA(W1), .WB(W1)) u_mrr (.clk(clk), .a(r_r[i]), .b(r_r[i]), .p(prr[i]));
  end

  // second order sums and the coincidence test
  logic signed [W3-1:0] uu_c;
  logic signed [W3-1:0] vv_c;
  logic signed [W3-1:0] uv_c;
  logic signed [W3-1:0] t2e;
  logic signed [W3-1:0] uu_r;
  logic signed [W3-1:0] vv_r;
  logic signed [W3-1:0] uv_r;
  logic signed [W3-1:0] k1_r;
  logic signed [W3-1:0] k2_r;
  logic                 ok1_r;

  assign uu_c = W3'(puu[0]) + W3'(puu[1]) + W3'(puu[2]);
  assign vv_c = W3'(pvv[0]) + W3'(pvv[1]) + W3'(pvv[2]);
  assign uv_c = W3'(puv[0]) + W3'(puv[1]) + W3'(puv[2]);
  assign t2e  = W3'(t2_r);

  always_ff @(posedge clk) begin
    uu_r  <= uu_c;
    vv_r  <= vv_c;
    uv_r  <= uv_c;
    k1_r  <= uu_c + W3'(prr[0]) - W3'(prr[1]);
    k2_r  <= vv_c + W3'(prr[0]) - W3'(prr[2]);
    ok1_r <= (uu_c != '0) && (uu_c >= t2e);
  end

  // fourth order products
  logic signed [2*W3-1:0] pdd_a;
  logic signed [2*W3-1:0] pdd_b;
  logic signed [2*W3-1:0] pal_a;
  logic signed [2*W3-1:0] pal_b;
  logic signed [2*W3-1:0] pbe_a;
  logic signed [2*W3-1:0] pbe_b;
  logic signed [2*W3-1:0] ptu;

  tsrc_mul #(.WA(W3), .WB(W3)) u_mdd_a (.clk(clk), .a(uu_r), .b(vv_r), .p(pdd_a));
  tsrc_mul #(.WA(W3), .WB(W3)) u_mdd_b (.clk(clk), .a(uv_r), .b(uv_r), .p(pdd_b));
  tsrc_mul #(.WA(W3), .WB(W3)) u_mal_a (.clk(clk), .a(k1_r), .b(vv_r), .p(pal_a));
  tsrc_mul #(.WA(W3), .WB(W3)) u_mal_b (.clk(clk), .a(k2_r), .b(uv_r), .p(pal_b));
  tsrc_mul #(.WA(W3), .WB(W3)) u_mbe_a (.clk(clk), .a(k2_r), .b(uu_r), .p(pbe_a));
  tsrc_mul #(.WA(W3), .WB(W3)) u_mbe_b (.clk(clk), .a(k1_r), .b(uv_r), .p(pbe_b));
  tsrc_mul #(.WA(W3), .WB(W3)) u_mtu   (.clk(clk), .a(t2e),  .b(uu_r), .p(ptu));

  logic ok1_d;

  tsrc_delay #(.W(1), .D(tsrc_pkg::LAT3)) u_dly_ok1 (.clk(clk), .d(ok1_r), .q(ok1_d));

  // determinant, frame coefficients and the collinearity test
  logic signed [W4-1:0] dd_c;
  logic signed [W4-1:0] dd_r;
  logic signed [W4-1:0] al_r;
  logic signed [W4-1:0] be_r;
  logic                 ok_r;

  assign dd_c = W4'(pdd_a) - W4'(pdd_b);

  always_ff @(posedge clk) begin
    dd_r <= dd_c;
    al_r <= W4'(pal_a) - W4'(pal_b);
    be_r <= W4'(pbe_a) - W4'(pbe_b);
    ok_r <= ok1_d && (dd_c != '0) && (dd_c >= W4'(ptu));
  end

  // frame vectors and first center carried alongside
  logic [6*W1-1:0]  uv_pk;
  logic [6*W1-1:0]  uv_dk;
  logic [3*C_W-1:0] p0_pk;
  logic [3*C_W-1:0] p0_dk;
  logic signed [W1-1:0]  u_d [3];
  logic signed [W1-1:0]  v_d [3];
  logic signed [C_W-1:0] p0_d [3];

  assign uv_pk = {u_r[0], u_r[1], u_r[2], v_r[0], v_r[1], v_r[2]};
  assign p0_pk = {p0_r[0], p0_r[1], p0_r[2]};

  tsrc_delay #(.W(6*W1), .D(D_UV)) u_dly_uv (.clk(clk), .d(uv_pk), .q(uv_dk));
  tsrc_delay #(.W(3*C_W), .D(D_P0)) u_dly_p0 (.clk(clk), .d(p0_pk), .q(p0_dk));

  assign {u_d[0], u_d[1], u_d[2], v_d[0], v_d[1], v_d[2]} = uv_dk;
  assign {p0_d[0], p0_d[1], p0_d[2]} = p0_dk;

  // numerators per coordinate
  logic signed [W5-1:0] pna [3];
  logic signed [W5-1:0] pnb [3];

  for (genvar i = 0; i < 3; i++) begin : g_m5
    tsrc_mul #(.WA(W4), .WB(W1)) u_mna (.clk(clk), .a(al_r), .b(u_d[i]), .p(pna[i]));
    tsrc_mul #(.WA(W4), .WB(W1)) u_mnb (.clk(clk), .a(be_r), .b(v_d[i]), .p(pnb[i]));
  end

  logic signed [W4-1:0] dd_d;
  logic                 ok_d;

  tsrc_delay #(.W(W4), .D(tsrc_pkg::LAT5)) u_dly_dd (.clk(clk), .d(dd_r), .q(dd_d));
  tsrc_delay #(.W(1), .D(D_OK)) u_dly_ok (.clk(clk), .d(ok_r), .q(ok_d));

  // rounded division operands: |n| + D over 2D
  logic [WN-1:0] num_r [3];
  logic          neg_r [3];
  logic [WD-1:0] d2_r;

  for (genvar i = 0; i < 3; i++) begin : g_l6
    logic signed [W6-1:0] n;
    logic [W6-1:0]        nabs;
    assign n    = W6'(pna[i]) + W6'(pnb[i]);
    assign nabs = n[W6-1] ? -n : n;
    always_ff @(posedge clk) begin
      num_r[i] <= WN'(nabs) + WN'($unsigned(dd_d));
      neg_r[i] <= n[W6-1];
    end
  end

  always_ff @(posedge clk) begin
    d2_r <= {$unsigned(dd_d), 1'b0};
  end

  // dividers and final sum with saturation
  tsrc_pkg::out_t out_r;
  logic signed [C_W-1:0] res [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [QW-1:0]        q;
    logic                 ovf;
    logic                 qneg;
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] sum;

    tsrc_div #(.WNUM(WN), .WDEN(WD), .QB(QW)) u_div (
      .clk   (clk),
      .num   (num_r[i]),
      .den   (d2_r),
      .neg   (neg_r[i]),
      .q     (q),
      .ovf   (ovf),
      .neg_o (qneg)
    );

    assign qs  = {2'b00, q};
    assign sum = SW'(p0_d[i]) + (qneg ? -qs : qs);

    always_comb begin
      if (!ok_d) begin
        res[i] = '0;
      end else if (ovf) begin
        res[i] = qneg ? tsrc_pkg::C_MIN : tsrc_pkg::C_MAX;
      end else if (sum > SW'(tsrc_pkg::C_MAX)) begin
        res[i] = tsrc_pkg::C_MAX;
      end else if (sum < SW'(tsrc_pkg::C_MIN)) begin
        res[i] = tsrc_pkg::C_MIN;
      end else begin
        res[i] = sum[C_W-1:0];
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    out_r.res_x <= res[0];
    out_r.res_y <= res[1];
    out_r.res_z <= res[2];
    out_r.found <= ok_d;
  end

  assign out_data   = out_r;
  assign out_strobe = vpipe_r[NV-1];

endmodule

// ===== src/tsrc_chk.sv =====
// ---------------------------------------------------------------------------
// tsrc_chk
// port level checker for the radical center block, bound to the top level
// ---------------------------------------------------------------------------
`include "three_sphere_radical_center_defines.svh"

module tsrc_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input tsrc_pkg::in_t              in_data,
  input logic                       out_strobe,
  input tsrc_pkg::out_t             out_data,
  input logic                       cfg_we,
  input logic [tsrc_pkg::THR_W-1:0] cfg_wdata
);

  // the block takes a beat in every cycle
  `TSRC_ASSERT_NEVER(a_never_busy, busy, "busy raised")

  // every accepted beat gives one result after the fixed latency
  `TSRC_ASSERT_IMP(a_start_result, start, ##(tsrc_pkg::NV) out_strobe, "result beat missing")

  // no result beat without a beat accepted at the matching edge
  `TSRC_ASSERT_IMP(a_result_origin, out_strobe, $past(start, tsrc_pkg::NV), "result beat invented")

  // degenerate results carry zero coordinates
  `TSRC_ASSERT_IMP(a_zero_when_not_found, out_strobe && !out_data.found, (out_data.res_x == 0) && (out_data.res_y == 0) && (out_data.res_z == 0), "degenerate result not zero")

endmodule

bind three_sphere_radical_center tsrc_chk u_tsrc_chk (.*);
